/* sv/prs_pkg.sv */
// Shared types and constants for the pointer registry set.
// Used by prs_cell and pointer_registry_set; depends on nothing else.
package prs_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int KEY_W     = 64;
   localparam int MODE_W    = 2;
   localparam int USED_W    = 5;
   localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int SAT_W     = (COUNT_W > USED_W) ? COUNT_W : USED_W;
   localparam int USED_MAX  = (1 << USED_W) - 1;

   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // Scan token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic               valid;
      logic               hit_seen;
      logic               free_seen;
      logic [COUNT_W-1:0] count;
   } link_type;

   // Write strobes broadcast to all cells once a scan has finished.
   typedef struct packed {
      logic add;
      logic remove;
   } commit_type;

   function automatic logic [USED_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
      logic [SAT_W-1:0] w;
      w = SAT_W'(c);
      if (w > SAT_W'(USED_MAX)) begin
         return USED_W'(USED_MAX);
      end
      return w[USED_W-1:0];
   endfunction

endpackage

/* sv/pointer_registry_set.sv */
// Pointer registry set: a table of NUM_SLOTS 64-bit keys, zero meaning empty.
// Depends on prs_pkg and prs_cell.
//
// The request channel (req_valid, req_stall, req_mode, req_key) carries one
// operation per transfer: query, add or remove of a key. The response channel
// (rsp_valid, rsp_stall, rsp_ok, rsp_used_count) returns exactly one result
// per request, in order, with the number of occupied slots after the step.
// A request is scanned by a token that walks the chain of slot cells, one
// cell per cycle; the token leaving the last cell is held in tail_ff, and
// the result is loaded into the output register once it is free. The block
// works on one request at a time and takes the next one the cycle after
// the result is loaded. The result sits in an output register, so a new
// request is taken while an earlier result still waits on rsp_stall; a
// finished scan holds its table update until that register is free. Reset
// empties every slot at once and leaves both channels idle; requests are
// accepted in the cycle after reset is released.
module pointer_registry_set (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [prs_pkg::MODE_W-1:0]  req_mode,
   input  logic [prs_pkg::KEY_W-1:0]   req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [prs_pkg::USED_W-1:0]  rsp_used_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                   state_ff;
   logic [prs_pkg::MODE_W-1:0]  mode_ff;
   logic [prs_pkg::KEY_W-1:0]   key_ff;
   prs_pkg::link_type           head_ff;
   prs_pkg::link_type           tail_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff;
   logic [prs_pkg::USED_W-1:0]  rsp_used_ff;

   prs_pkg::link_type           links [0:prs_pkg::NUM_SLOTS];
   prs_pkg::commit_type         commit;

   logic                        req_take;
   logic                        out_free;
   logic                        present;
   logic                        fin_ok;
   logic [prs_pkg::COUNT_W-1:0] fin_count;

   assign links[0] = head_ff;

   for (genvar i = 0; i < prs_pkg::NUM_SLOTS; i++) begin : g_cell
      prs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .key      (key_ff),
         .link_in  (links[i]),
         .commit   (commit),
         .link_out (links[i+1])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      present    = (key_ff != '0) && tail_ff.hit_seen;
      fin_ok     = 1'b0;
      fin_count  = tail_ff.count;
      case (mode_ff)
         prs_pkg::MODE_QUERY: begin
            fin_ok = present;
         end
         prs_pkg::MODE_ADD: begin
            fin_ok = !present && tail_ff.free_seen;
            if (fin_ok && key_ff != '0) begin
               fin_count = tail_ff.count + prs_pkg::COUNT_W'(1);
            end
         end
         prs_pkg::MODE_REMOVE: begin
            fin_ok = tail_ff.hit_seen;
            if (fin_ok && key_ff != '0) begin
               fin_count = tail_ff.count - prs_pkg::COUNT_W'(1);
            end
         end
         default: begin
            fin_ok = 1'b0;
         end
      endcase

      // The table is written only in the cycle the result is loaded.
      commit.add    = (state_ff == ST_FINISH) && out_free
                      && (mode_ff == prs_pkg::MODE_ADD) && fin_ok;
      commit.remove = (state_ff == ST_FINISH) && out_free
                      && (mode_ff == prs_pkg::MODE_REMOVE) && fin_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff.valid <= req_take;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (links[prs_pkg::NUM_SLOTS].valid) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      if (req_take) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      head_ff.hit_seen  <= 1'b0;
      head_ff.free_seen <= 1'b0;
      head_ff.count     <= '0;
      if (state_ff == ST_SCAN && links[prs_pkg::NUM_SLOTS].valid) begin
         tail_ff <= links[prs_pkg::NUM_SLOTS];
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_ok_ff   <= fin_ok;
         rsp_used_ff <= prs_pkg::sat_count(fin_count);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_used_count = rsp_used_ff;

   a_commit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(commit.add && commit.remove))
      else $error("add and remove commits asserted together");

   a_tail_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      links[prs_pkg::NUM_SLOTS].valid |-> (state_ff == ST_SCAN))
      else $error("scan token left the chain outside a scan");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (req_stall && !rsp_valid_ff) || (req_stall && $past(rsp_valid_ff)))
      else $error("request transfer did not start a scan");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_used_count) <= prs_pkg::NUM_SLOTS))
      else $error("occupied count exceeds the table size");

endmodule

/* sv/prs_cell.sv */
// One slot of the registry: holds a key and takes part in the chained scan.
// Depends on prs_pkg for the link and commit types.
module prs_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [prs_pkg::KEY_W-1:0] key,
   input  prs_pkg::link_type        link_in,
   input  prs_pkg::commit_type      commit,
   output prs_pkg::link_type        link_out
);

   logic [prs_pkg::KEY_W-1:0] slot_ff, slot_in;
   logic                      first_hit_ff, first_hit_in;
   logic                      first_free_ff, first_free_in;
   prs_pkg::link_type         link_ff, link_in_next;
   logic                      match, empty;

   assign match = (slot_ff == key);
   assign empty = (slot_ff == '0);

   always_comb begin
      slot_in = slot_ff;
      if (commit.add && first_free_ff) begin
         slot_in = key;
      end else if (commit.remove && first_hit_ff) begin
         slot_in = '0;
      end

      // A cell is the first hit or first free one when no earlier cell claimed it.
      first_hit_in  = first_hit_ff;
      first_free_in = first_free_ff;
      if (link_in.valid) begin
         first_hit_in  = match && !link_in.hit_seen;
         first_free_in = empty && !link_in.free_seen;
      end

      link_in_next.valid     = link_in.valid;
      link_in_next.hit_seen  = link_in.hit_seen || match;
      link_in_next.free_seen = link_in.free_seen || empty;
      link_in_next.count     = link_in.count + prs_pkg::COUNT_W'(!empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         first_hit_ff  <= 1'b0;
         first_free_ff <= 1'b0;
         link_ff.valid <= 1'b0;
      end else begin
         slot_ff       <= slot_in;
         first_hit_ff  <= first_hit_in;
         first_free_ff <= first_free_in;
         link_ff.valid <= link_in_next.valid;
      end
      link_ff.hit_seen  <= link_in_next.hit_seen;
      link_ff.free_seen <= link_in_next.free_seen;
      link_ff.count     <= link_in_next.count;
   end

   assign link_out = link_ff;

endmodule

/* tb/pointer_registry_set_tb.sv */
// Self-checking testbench for pointer_registry_set: a mirror of the key table
// predicts every response, which a monitor checks in order.
// Depends on prs_pkg and the pointer_registry_set RTL.
module pointer_registry_set_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [prs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [prs_pkg::KEY_W-1:0]  KEY_NULL    = '0;
   localparam logic [prs_pkg::KEY_W-1:0]  KEY_ONES    = '1;
   localparam logic [prs_pkg::KEY_W-1:0]  KEY_TOP_BIT = 64'h8000_0000_0000_0000;
   localparam int RANDOM_BLOCKS = 15;
   localparam int BLOCK_ITEMS   = 102;
   localparam int POOL_SIZE     = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * prs_pkg::NUM_SLOTS + 8;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int PRINT_LIMIT   = 200;

   typedef struct packed {
      logic                       ok;
      logic [prs_pkg::USED_W-1:0] used;
   } reply_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [prs_pkg::MODE_W-1:0] req_mode;
   logic [prs_pkg::KEY_W-1:0]  req_key;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_ok;
   logic [prs_pkg::USED_W-1:0] rsp_used_count;

   // Mirror of the key table, updated when a request transfer happens.
   logic [prs_pkg::KEY_W-1:0] mirror_slots [prs_pkg::NUM_SLOTS];
   logic [prs_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
   reply_type                 pending_replies [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit req_gaps_on    = 1'b0;
   bit rsp_stalls_on  = 1'b0;
   bit hold_request   = 1'b0;

   pointer_registry_set u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_used_count (rsp_used_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [prs_pkg::KEY_W-1:0] random_key();
      logic [prs_pkg::KEY_W-1:0] k;
      k = {$urandom, $urandom};
      if (k == KEY_NULL) begin
         k = 64'd1;
      end
      return k;
   endfunction

   function automatic logic [prs_pkg::KEY_W-1:0] pick_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick < 75) begin
         return KEY_NULL;
      end else if (pick < 85) begin
         // A near miss: one bit away from a key that is likely stored.
         return key_pool[$urandom_range(0, POOL_SIZE - 1)]
                ^ (64'd1 << $urandom_range(0, prs_pkg::KEY_W - 1));
      end
      return random_key();
   endfunction

   function automatic int occupied_slots();
      int n;
      n = 0;
      foreach (mirror_slots[i]) begin
         if (mirror_slots[i] != KEY_NULL) begin
            n++;
         end
      end
      return n;
   endfunction

   // Applies one operation to the mirror table and queues the response it implies.
   // A null key matches any empty slot, which is why add and remove of the null
   // key succeed exactly when the table has room.
   function automatic void record_op(input logic [prs_pkg::MODE_W-1:0] mode,
                                     input logic [prs_pkg::KEY_W-1:0] key);
      int        hit_idx;
      int        free_idx;
      int        used;
      logic      present;
      reply_type r;
      hit_idx  = -1;
      free_idx = -1;
      for (int i = prs_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (mirror_slots[i] == key) hit_idx = i;
         if (mirror_slots[i] == KEY_NULL) free_idx = i;
      end
      present = (key != KEY_NULL) && (hit_idx >= 0);
      r.ok = 1'b0;
      case (mode)
         prs_pkg::MODE_QUERY: begin
            r.ok = present;
         end
         prs_pkg::MODE_ADD: begin
            if (!present && free_idx >= 0) begin
               mirror_slots[free_idx] = key;
               r.ok = 1'b1;
            end
         end
         prs_pkg::MODE_REMOVE: begin
            if (hit_idx >= 0) begin
               mirror_slots[hit_idx] = KEY_NULL;
               r.ok = 1'b1;
            end
         end
         default: begin
            r.ok = 1'b0;
         end
      endcase
      used = occupied_slots();
      if (used > prs_pkg::USED_MAX) used = prs_pkg::USED_MAX;
      r.used = used[prs_pkg::USED_W-1:0];
      pending_replies.push_back(r);
   endfunction

   // Offers one request and returns at the edge of its transfer with valid still
   // high, so a following request can go out back to back.
   task automatic send_op(input logic [prs_pkg::MODE_W-1:0] mode,
                          input logic [prs_pkg::KEY_W-1:0] key);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_key   <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      record_op(mode, key);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_replies_done();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Response monitor: every transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_replies.size() == 0) begin
            flag_mismatch($sformatf("response with none pending: ok=%0b used=%0d",
                                    rsp_ok, rsp_used_count));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ok !== want.ok) begin
               flag_mismatch($sformatf("rsp_ok is %0b, predicted %0b", rsp_ok, want.ok));
            end
            if (rsp_used_count !== want.used) begin
               flag_mismatch($sformatf("rsp_used_count is %0d, predicted %0d",
                                       rsp_used_count, want.used));
            end
         end
      end
   end

   // Response side: random stalls, or one long hold-off when a test asks for it.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (1 + pick_gap()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Null key on an empty table, duplicates, reuse of a freed slot, unused mode,
   // and keys at the extremes of the field.
   task automatic test_directed();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_op(prs_pkg::MODE_QUERY, KEY_NULL);
      send_op(prs_pkg::MODE_REMOVE, KEY_NULL);
      send_op(prs_pkg::MODE_ADD, KEY_NULL);
      send_op(prs_pkg::MODE_QUERY, KEY_ONES);
      send_op(prs_pkg::MODE_REMOVE, 64'd5);
      send_op(prs_pkg::MODE_ADD, KEY_ONES);
      send_op(prs_pkg::MODE_ADD, KEY_TOP_BIT);
      send_op(prs_pkg::MODE_ADD, 64'd1);
      send_op(prs_pkg::MODE_ADD, KEY_ONES);
      send_op(prs_pkg::MODE_QUERY, KEY_ONES);
      send_op(prs_pkg::MODE_QUERY, KEY_TOP_BIT | 64'd1);
      send_op(prs_pkg::MODE_REMOVE, KEY_TOP_BIT);
      send_op(prs_pkg::MODE_ADD, 64'h5555_5555_5555_5555);
      send_op(prs_pkg::MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
      send_op(prs_pkg::MODE_QUERY, KEY_NULL);
      send_op(MODE_UNUSED, KEY_ONES);
      send_op(MODE_UNUSED, KEY_NULL);
      send_op(prs_pkg::MODE_REMOVE, KEY_ONES);
      send_op(prs_pkg::MODE_REMOVE, 64'd1);
      send_op(prs_pkg::MODE_REMOVE, 64'h5555_5555_5555_5555);
      send_op(prs_pkg::MODE_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_op(prs_pkg::MODE_REMOVE, 64'd1);
      end_burst();
      wait_replies_done();
   endtask

   // Fills the table with random keys, tries every operation on a full table,
   // then empties it in random order.
   task automatic test_full_table();
      logic [prs_pkg::KEY_W-1:0] stored [$];
      logic [prs_pkg::KEY_W-1:0] k;
      int                        idx;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      while (occupied_slots() < prs_pkg::NUM_SLOTS) begin
         k = random_key();
         stored.push_back(k);
         send_op(prs_pkg::MODE_ADD, k);
      end
      send_op(prs_pkg::MODE_ADD, random_key());
      send_op(prs_pkg::MODE_ADD, stored[$urandom_range(0, stored.size() - 1)]);
      send_op(prs_pkg::MODE_ADD, KEY_NULL);
      send_op(prs_pkg::MODE_REMOVE, KEY_NULL);
      send_op(prs_pkg::MODE_QUERY, KEY_NULL);
      send_op(prs_pkg::MODE_QUERY, stored[$urandom_range(0, stored.size() - 1)]);
      while (stored.size() > 0) begin
         idx = $urandom_range(0, stored.size() - 1);
         k   = stored[idx];
         stored.delete(idx);
         send_op(prs_pkg::MODE_REMOVE, k);
         if ($urandom_range(0, 3) == 0) begin
            send_op(prs_pkg::MODE_QUERY, k);
         end
      end
      end_burst();
      wait_replies_done();
   endtask

   // The response side holds off while requests keep coming, so the block fills
   // and stalls its input; afterwards the request side waits for a full drain.
   task automatic test_backpressure();
      logic [prs_pkg::KEY_W-1:0] k;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      hold_request  = 1'b1;
      repeat (6) begin
         k = random_key();
         send_op(prs_pkg::MODE_ADD, k);
         send_op(prs_pkg::MODE_QUERY, k);
      end
      end_burst();
      wait_replies_done();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (4) send_op(prs_pkg::MODE_REMOVE, pick_key());
      end_burst();
      wait_replies_done();
   endtask

   // Blocks of random traffic over a small key pool, so that hits, misses, a
   // full table and an empty one all come up; the add bias changes per block.
   task automatic test_random_mix();
      int                         add_weight;
      int                         pick;
      logic [prs_pkg::MODE_W-1:0] mode;
      foreach (key_pool[i]) key_pool[i] = random_key();
      key_pool[0] = KEY_ONES;
      key_pool[1] = 64'd1;
      key_pool[2] = KEY_TOP_BIT;
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         add_weight    = $urandom_range(25, 60);
         req_gaps_on   = (b != 0) && ($urandom_range(0, 2) != 0);
         rsp_stalls_on = (b != 0) && ($urandom_range(0, 2) != 0);
         repeat (BLOCK_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < add_weight) begin
               mode = prs_pkg::MODE_ADD;
            end else if (pick < add_weight + 30) begin
               mode = prs_pkg::MODE_REMOVE;
            end else begin
               mode = prs_pkg::MODE_QUERY;
            end
            send_op(mode, pick_key());
         end
      end
      end_burst();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_mode  <= prs_pkg::MODE_QUERY;
      req_key   <= KEY_NULL;
      foreach (mirror_slots[i]) mirror_slots[i] = KEY_NULL;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random_mix();
      wait_replies_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
sv/prs_pkg.sv
sv/prs_cell.sv
sv/pointer_registry_set.sv
tb/pointer_registry_set_tb.sv
